>>> design/vertex_dedup_indexer_defines.svh
// Assertion macros for the vertex dedup indexer.
// Used by vdi_checker; no other dependencies.
`ifndef VERTEX_DEDUP_INDEXER_DEFINES_SVH
`define VERTEX_DEDUP_INDEXER_DEFINES_SVH

// same-cycle implication
`define VDI_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VDI_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/vdi_pkg.sv
// Shared types and constants for the vertex dedup indexer.
// No dependencies.
`default_nettype none

package vdi_pkg;

    localparam int COORD_W     = 32;
    localparam int POINT_W     = 3 * COORD_W;
    localparam int IDX_FIELD_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vdi_cmd_t;

endpackage

`default_nettype wire

>>> design/vdi_front.sv
// Input stage: registers the incoming word and turns it into a command.
// Depends on vdi_pkg.
`default_nettype none

module vdi_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [vdi_pkg::POINT_W-1:0]   in_data,
    input  wire logic                          in_start,
    output logic                               cmd_valid,
    input  wire logic                          cmd_ready,
    output vdi_pkg::vdi_cmd_t                  cmd
);

    logic              hold_vld_reg;
    logic              hold_vld_next;
    vdi_pkg::vdi_cmd_t hold_cmd_reg;
    vdi_pkg::vdi_cmd_t hold_cmd_next;
    logic              take;

    assign in_ready  = !hold_vld_reg || cmd_ready;
    assign take      = in_valid && in_ready;
    assign cmd_valid = hold_vld_reg;
    assign cmd       = hold_cmd_reg;

    always_comb
    begin
        hold_vld_next = hold_vld_reg;
        hold_cmd_next = hold_cmd_reg;
        if (hold_vld_reg && cmd_ready)
        begin
            hold_vld_next = 1'b0;
        end
        if (take)
        begin
            hold_vld_next     = 1'b1;
            hold_cmd_next.x     = in_data[vdi_pkg::COORD_W-1:0];
            hold_cmd_next.y     = in_data[2*vdi_pkg::COORD_W-1:vdi_pkg::COORD_W];
            hold_cmd_next.z     = in_data[3*vdi_pkg::COORD_W-1:2*vdi_pkg::COORD_W];
            hold_cmd_next.start = in_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_cmd_reg <= hold_cmd_next;
    end

endmodule

`default_nettype wire

>>> design/vdi_queue.sv
// Short command queue between the input stage and the search engine.
// Depends on vdi_pkg.
`default_nettype none

module vdi_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire vdi_pkg::vdi_cmd_t push_cmd,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output vdi_pkg::vdi_cmd_t      pop_cmd
);

    vdi_pkg::vdi_cmd_t              entries_reg [vdi_pkg::QUEUE_DEPTH];
    logic [vdi_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [vdi_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [vdi_pkg::QPTR_W:0]       fill_reg;
    logic                           do_push;
    logic                           do_pop;

    assign push_ready = fill_reg != (vdi_pkg::QPTR_W+1)'(vdi_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_cmd    = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> design/vdi_back.sv
// Search engine: vertex memory, sequential scan, append and result register.
// Depends on vdi_pkg.
`default_nettype none

module vdi_back #(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cmd_valid,
    output logic                                  cmd_ready,
    input  wire vdi_pkg::vdi_cmd_t                cmd,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [vdi_pkg::IDX_FIELD_W-1:0]       out_index,
    output logic                                  out_new,
    output logic                                  out_full
);

    localparam int IW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (CW > vdi_pkg::IDX_FIELD_W) ? CW : vdi_pkg::IDX_FIELD_W;
    localparam logic [CW-1:0] MAXC = CW'(MAX_VERTICES);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t                          state_reg, state_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   rd_idx_reg, rd_idx_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0]                   cmp_idx_reg, cmp_idx_next;
    logic [vdi_pkg::POINT_W-1:0]     pt_reg, pt_next;
    logic                            hit_reg, hit_next;
    logic [CW-1:0]                   res_idx_reg, res_idx_next;
    logic                            out_valid_reg, out_valid_next;
    logic [vdi_pkg::IDX_FIELD_W-1:0] out_index_reg, out_index_next;
    logic                            out_new_reg, out_new_next;
    logic                            out_full_reg, out_full_next;

    logic [vdi_pkg::POINT_W-1:0]     vtx_mem [MAX_VERTICES];
    logic [vdi_pkg::POINT_W-1:0]     rd_data_reg;
    logic                            wr_en;
    logic [CW-1:0]                   fin_idx;
    logic [EW-1:0]                   idx_ext;

    assign cmd_ready = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_new   = out_new_reg;
    assign out_full  = out_full_reg;
    assign idx_ext   = EW'(fin_idx);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        pt_next        = pt_reg;
        hit_next       = hit_reg;
        res_idx_next   = res_idx_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        wr_en          = 1'b0;
        fin_idx        = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    pt_next      = {cmd.z, cmd.y, cmd.x};
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    hit_next     = 1'b0;
                    if (cmd.start)
                    begin
                        count_next = '0;
                    end
                    if (cmd.start || count_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmp_vld_next = rd_idx_reg < count_reg;
                cmp_idx_next = rd_idx_reg;
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (cmp_vld_reg)
                begin
                    if (rd_data_reg == pt_reg)
                    begin
                        hit_next     = 1'b1;
                        res_idx_next = cmp_idx_reg;
                        state_next   = ST_FINISH;
                    end
                    else if (cmp_idx_reg == count_reg - CW'(1))
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_new_next   = 1'b0;
                    out_full_next  = 1'b0;
                    if (hit_reg)
                    begin
                        fin_idx = res_idx_reg;
                    end
                    else if (count_reg == MAXC)
                    begin
                        out_full_next = 1'b1;
                    end
                    else
                    begin
                        fin_idx      = count_reg;
                        out_new_next = 1'b1;
                        wr_en        = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                    out_index_next = idx_ext[vdi_pkg::IDX_FIELD_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            pt_reg        <= '0;
            hit_reg       <= 1'b0;
            res_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_new_reg   <= 1'b0;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            pt_reg        <= pt_next;
            hit_reg       <= hit_next;
            res_idx_reg   <= res_idx_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
            out_new_reg   <= out_new_next;
            out_full_reg  <= out_full_next;
        end
    end

    // vertex memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            vtx_mem[count_reg[IW-1:0]] <= pt_reg;
        end
        rd_data_reg <= vtx_mem[rd_idx_reg[IW-1:0]];
    end

endmodule

`default_nettype wire

>>> design/vertex_dedup_indexer.sv
// Top level of the vertex dedup indexer: input stage, queue, search engine.
// Depends on vdi_pkg, vdi_front, vdi_queue, vdi_back.
//
//  port group   dir  tdata (low bit up)                 tuser
//  s_axis       in   coord_x, coord_y, coord_z (96)     mesh_start
//  m_axis       out  vertex_index (8)                   was_new, table_full
//
// Lookup: with an empty table or mesh_start the scan is skipped; else
// the vertex memory is scanned one entry per cycle through its single
// read port, until a hit or the last stored entry.
// Reset: rst_n asynchronous, active low; clears the vertex count, no sweep.
// Words still enter the queue while a result waits on m_axis, until full.
`default_nettype none

module vertex_dedup_indexer #(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
    input  wire logic [0:0]  s_axis_tuser,   // mesh_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // vertex_index
    output logic [1:0]       m_axis_tuser    // was_new, table_full
);

    logic              fq_valid;
    logic              fq_ready;
    vdi_pkg::vdi_cmd_t fq_cmd;
    logic              qb_valid;
    logic              qb_ready;
    vdi_pkg::vdi_cmd_t qb_cmd;

    vdi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (s_axis_tdata),
        .in_start  (s_axis_tuser[0]),
        .cmd_valid (fq_valid),
        .cmd_ready (fq_ready),
        .cmd       (fq_cmd)
    );

    vdi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    vdi_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_ready (qb_ready),
        .cmd       (qb_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (m_axis_tdata),
        .out_new   (m_axis_tuser[0]),
        .out_full  (m_axis_tuser[1])
    );

endmodule

`default_nettype wire

>>> design/vdi_checker.sv
// Port-level checks for the vertex dedup indexer, bound to the top level.
// Depends on vertex_dedup_indexer_defines.svh.
`default_nettype none
`include "vertex_dedup_indexer_defines.svh"

module vdi_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser
);

    `VDI_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed while stalled")
    `VDI_ASSERT_IMP(a_flags_excl, clk, rst_n, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "was_new and table_full both set")
    `VDI_ASSERT_IMP(a_full_idx, clk, rst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata == 8'd0, "dropped point with nonzero index")
    `VDI_ASSERT_IMP(a_hs_known, clk, rst_n, s_axis_tvalid, !$isunknown(s_axis_tready) && !$isunknown(m_axis_tvalid), "handshake unknown")

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
